[src/long_press_radio_toggle_controller_core_defines.svh]
// assertion macros for the long-press radio toggle controller
`ifndef LONG_PRESS_RADIO_TOGGLE_CONTROLLER_CORE_DEFINES_SVH
`define LONG_PRESS_RADIO_TOGGLE_CONTROLLER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LPRT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LPRT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LPRT_ASSERT_IMP(lbl, ante, cons, msg)
`define LPRT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[src/lprt_pkg.sv]
// types, constants and codes for the long-press radio toggle controller
package lprt_pkg;

	localparam int unsigned HOLD_W = 16;
	localparam int unsigned IDLE_W = 26;
	localparam int unsigned CFG_W  = 26;
	localparam int unsigned IDX_W  = 2;

	localparam logic [HOLD_W-1:0] SHORT_HOLD_RST = 16'd3000;
	localparam logic [HOLD_W-1:0] LONG_HOLD_RST  = 16'd30000;
	localparam logic [IDLE_W-1:0] AUTO_OFF_RST   = 26'd600000;
	localparam logic [IDLE_W-1:0] IDLE_MAX       = {IDLE_W{1'b1}};

	typedef enum logic [1:0] {
		KIND_TICK     = 2'd0,
		KIND_ACTIVITY = 2'd1,
		KIND_START    = 2'd2,
		KIND_STOP     = 2'd3
	} kind_t;

	typedef enum logic [IDX_W-1:0] {
		REG_SHORT_HOLD = 2'd0,
		REG_LONG_HOLD  = 2'd1,
		REG_AUTO_OFF   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [HOLD_W-1:0] short_hold_ms;
		logic [HOLD_W-1:0] long_hold_ms;
		logic [IDLE_W-1:0] auto_off_ms;
	} cfg_t;

	typedef struct packed {
		logic              button_prev;
		logic              press_tracked;
		logic [HOLD_W-1:0] hold_time;
		logic              tone_flag;
		logic              active_flag;
		logic [IDLE_W-1:0] idle_time;
	} state_t;

	typedef struct packed {
		logic service_active;
		logic tone_on;
		logic went_up;
		logic went_down;
		logic password_reset;
		logic beep_three;
		logic user_activity;
	} result_t;

endpackage

[src/lprt_cfg.sv]
// configuration register bank
module lprt_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [lprt_pkg::IDX_W-1:0]   cfg_index,
	input  logic [lprt_pkg::CFG_W-1:0]   cfg_wdata,
	output lprt_pkg::cfg_t               cfg
);

	lprt_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_hold_ms <= lprt_pkg::SHORT_HOLD_RST;
			cfg_q.long_hold_ms  <= lprt_pkg::LONG_HOLD_RST;
			cfg_q.auto_off_ms   <= lprt_pkg::AUTO_OFF_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lprt_pkg::REG_SHORT_HOLD: begin
					cfg_q.short_hold_ms <= cfg_wdata[lprt_pkg::HOLD_W-1:0];
				end
				lprt_pkg::REG_LONG_HOLD: begin
					cfg_q.long_hold_ms <= cfg_wdata[lprt_pkg::HOLD_W-1:0];
				end
				lprt_pkg::REG_AUTO_OFF: begin
					cfg_q.auto_off_ms <= cfg_wdata[lprt_pkg::IDLE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/lprt_step.sv]
// next-state and result logic for one item
module lprt_step (
	input  lprt_pkg::cfg_t   cfg,
	input  lprt_pkg::state_t st,
	input  logic [1:0]       kind,
	input  logic             button_level,
	input  logic             start_ok,
	output lprt_pkg::state_t st_next,
	output lprt_pkg::result_t res
);

	logic [lprt_pkg::HOLD_W-1:0] cap;
	logic                        press;
	logic                        release_edge;
	logic                        up;
	logic                        down;
	logic                        pwd;
	logic                        beeps;
	logic                        act;
	lprt_pkg::state_t            s;

	always_comb begin
		cap          = (cfg.short_hold_ms > cfg.long_hold_ms) ? cfg.short_hold_ms
			: cfg.long_hold_ms;
		press        = st.button_prev && !button_level;
		release_edge = !st.button_prev && button_level;
		up    = 1'b0;
		down  = 1'b0;
		pwd   = 1'b0;
		beeps = 1'b0;
		act   = 1'b0;
		s     = st;
		case (lprt_pkg::kind_t'(kind))
			lprt_pkg::KIND_TICK: begin
				if (s.active_flag && s.idle_time != lprt_pkg::IDLE_MAX) begin
					s.idle_time = s.idle_time + 1'b1;
				end
				if (s.press_tracked && s.hold_time < cap) begin
					s.hold_time = s.hold_time + 1'b1;
				end
				if (press) begin
					s.press_tracked = 1'b1;
					s.hold_time     = '0;
					s.tone_flag     = 1'b0;
					act             = 1'b1;
				end
				if (!button_level && s.press_tracked && s.hold_time >= cfg.short_hold_ms) begin
					s.tone_flag = 1'b1;
				end
				if (release_edge && s.press_tracked) begin
					s.press_tracked = 1'b0;
					s.tone_flag     = 1'b0;
					if (s.hold_time >= cfg.long_hold_ms) begin
						pwd = 1'b1;
						if (s.active_flag) begin
							down = 1'b1;
							s.active_flag = start_ok;
							up = start_ok;
							if (start_ok) begin
								s.idle_time = '0;
							end
						end
					end else if (s.hold_time >= cfg.short_hold_ms) begin
						if (s.active_flag) begin
							s.active_flag = 1'b0;
							down = 1'b1;
						end else begin
							beeps = 1'b1;
							if (start_ok) begin
								s.active_flag = 1'b1;
								s.idle_time   = '0;
								up            = 1'b1;
							end
						end
					end
				end
				s.button_prev = button_level;
				if (s.active_flag && s.idle_time > cfg.auto_off_ms) begin
					s.active_flag = 1'b0;
					down = 1'b1;
				end
			end
			lprt_pkg::KIND_ACTIVITY: begin
				if (s.active_flag) begin
					s.idle_time = '0;
				end
				act = 1'b1;
			end
			lprt_pkg::KIND_START: begin
				if (!s.active_flag && start_ok) begin
					s.active_flag = 1'b1;
					s.idle_time   = '0;
					up            = 1'b1;
				end
			end
			default: begin
				if (s.active_flag) begin
					s.active_flag = 1'b0;
					down = 1'b1;
				end
			end
		endcase
		st_next = s;
		res.service_active = s.active_flag;
		res.tone_on        = s.tone_flag;
		res.went_up        = up;
		res.went_down      = down;
		res.password_reset = pwd;
		res.beep_three     = beeps;
		res.user_activity  = act;
	end

endmodule

[src/long_press_radio_toggle_controller_core.sv]
// Long-press radio toggle controller: one input item is taken every cycle unless a stalled
// output backs up into the input register. An accepted item is registered in the input
// register, then the step logic applies it to the controller state and writes its result
// into the result register, from which it is presented to the output side. Throughput is
// one item per cycle while the output side is not stalled, set by the single pass through the
// step logic between these two registers; a stalled output holds the result register and
// the input register behind it.
// Configuration writes take effect at the edge of the write.
`include "long_press_radio_toggle_controller_core_defines.svh"

module long_press_radio_toggle_controller_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lprt_pkg::IDX_W-1:0] cfg_index,
	input  logic [lprt_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 kind,
	input  logic                       button_level,
	input  logic                       start_ok,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       service_active,
	output logic                       tone_on,
	output logic                       went_up,
	output logic                       went_down,
	output logic                       password_reset,
	output logic                       beep_three,
	output logic                       user_activity
);

	lprt_pkg::cfg_t    cfg;
	lprt_pkg::state_t  st_q;
	lprt_pkg::state_t  st_next;
	lprt_pkg::result_t res;
	lprt_pkg::result_t res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic [1:0]        kind_s1;
	logic              level_s1;
	logic              ok_s1;
	logic              advance;

	lprt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	lprt_step u_step (
		.cfg          (cfg),
		.st           (st_q),
		.kind         (kind_s1),
		.button_level (level_s1),
		.start_ok     (ok_s1),
		.st_next      (st_next),
		.res          (res)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1  <= kind;
			level_s1 <= button_level;
			ok_s1    <= start_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.button_prev   <= 1'b1;
			st_q.press_tracked <= 1'b0;
			st_q.hold_time     <= '0;
			st_q.tone_flag     <= 1'b0;
			st_q.active_flag   <= 1'b0;
			st_q.idle_time     <= '0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	assign out_valid      = valid_s2;
	assign service_active = res_s2.service_active;
	assign tone_on        = res_s2.tone_on;
	assign went_up        = res_s2.went_up;
	assign went_down      = res_s2.went_down;
	assign password_reset = res_s2.password_reset;
	assign beep_three     = res_s2.beep_three;
	assign user_activity  = res_s2.user_activity;

	`LPRT_ASSERT_IMP(a_stall_only_when_full, !in_ready, valid_s1 && valid_s2 && !out_ready, "input stalled without a full pipe")
	`LPRT_ASSERT_NXT(a_state_tracks_result, advance, st_q.active_flag == res_s2.service_active && st_q.tone_flag == res_s2.tone_on, "state and result disagree")
	`LPRT_ASSERT_IMP(a_up_means_active, valid_s2 && went_up, service_active, "start reported on an inactive service")
	`LPRT_ASSERT_IMP(a_beeps_exclusive, valid_s2 && beep_three, !went_down && !password_reset, "beeps with stop or password reset")

endmodule

[verif/long_press_radio_toggle_controller_core_tb.sv]
// testbench for the long-press radio toggle controller: random button holds against a predictor
`timescale 1ns / 1ps

module long_press_radio_toggle_controller_core_tb;
	import lprt_pkg::*;

	localparam logic [IDX_W-1:0] UNUSED_REG = 2'd3;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct {
		kind_t k;
		logic  lvl;
		logic  ok;
	} ctrl_item_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        kind = KIND_TICK;
	logic              button_level = 1'b1;
	logic              start_ok = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              service_active;
	logic              tone_on;
	logic              went_up;
	logic              went_down;
	logic              password_reset;
	logic              beep_three;
	logic              user_activity;

	long_press_radio_toggle_controller_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.button_level   (button_level),
		.start_ok       (start_ok),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.service_active (service_active),
		.tone_on        (tone_on),
		.went_up        (went_up),
		.went_down      (went_down),
		.password_reset (password_reset),
		.beep_three     (beep_three),
		.user_activity  (user_activity)
	);

	// controller state as predicted
	logic [HOLD_W-1:0] short_ms;
	logic [HOLD_W-1:0] long_ms;
	logic [IDLE_W-1:0] auto_off;
	logic              btn_prev = 1'b1;
	logic              tracking = 1'b0;
	logic [HOLD_W-1:0] hold_ms = '0;
	logic              tone = 1'b0;
	logic              svc_on = 1'b0;
	logic [IDLE_W-1:0] idle_ms = '0;

	ctrl_item_t items_to_send[$];
	result_t    predicted_status[$];
	logic       in_taken = 1'b0;
	int         tx_idle_pct = 12;
	int         rx_idle_pct = 88;
	int         hold_off_asked = 0;
	int         hold_off_served = 0;
	int         hold_off_left = 0;
	int         mismatches = 0;
	int         results_checked = 0;
	int         starts_seen = 0;
	int         stops_seen = 0;
	int         resets_seen = 0;
	int         beeps_seen = 0;
	int         threshold_sets = 0;
	string      field_names [7] = '{"user_activity", "beep_three", "password_reset",
		"went_down", "went_up", "tone_on", "service_active"};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic power_up(logic ok);
		if (svc_on || !ok)
			return 1'b0;
		svc_on = 1'b1;
		idle_ms = '0;
		return 1'b1;
	endfunction

	function automatic result_t step_controller(kind_t k, logic lvl, logic ok);
		result_t           r;
		logic [HOLD_W-1:0] cap;
		logic              press_edge;
		logic              release_edge;
		r = '0;
		case (k)
			KIND_TICK: begin
				cap = (short_ms > long_ms) ? short_ms : long_ms;
				press_edge = btn_prev && !lvl;
				release_edge = !btn_prev && lvl;
				if (svc_on && idle_ms < IDLE_MAX)
					idle_ms = idle_ms + 1'b1;
				if (tracking && hold_ms < cap)
					hold_ms = hold_ms + 1'b1;
				if (press_edge) begin
					tracking = 1'b1;
					hold_ms = '0;
					tone = 1'b0;
					r.user_activity = 1'b1;
				end
				if (!lvl && tracking && hold_ms >= short_ms)
					tone = 1'b1;
				if (release_edge && tracking) begin
					tracking = 1'b0;
					tone = 1'b0;
					if (hold_ms >= long_ms) begin
						r.password_reset = 1'b1;
						if (svc_on) begin
							svc_on = 1'b0;
							r.went_down = 1'b1;
							r.went_up = power_up(ok);
						end
					end else if (hold_ms >= short_ms) begin
						if (svc_on) begin
							svc_on = 1'b0;
							r.went_down = 1'b1;
						end else begin
							r.went_up = power_up(ok);
							r.beep_three = 1'b1;
						end
					end
				end
				btn_prev = lvl;
				if (svc_on && idle_ms > auto_off) begin
					svc_on = 1'b0;
					r.went_down = 1'b1;
				end
			end
			KIND_ACTIVITY: begin
				if (svc_on)
					idle_ms = '0;
				r.user_activity = 1'b1;
			end
			KIND_START: r.went_up = power_up(ok);
			default: begin
				if (svc_on) begin
					svc_on = 1'b0;
					r.went_down = 1'b1;
				end
			end
		endcase
		r.service_active = svc_on;
		r.tone_on = tone;
		return r;
	endfunction

	function automatic void push_item(kind_t k, logic lvl, logic ok);
		items_to_send.push_back('{k, lvl, ok});
	endfunction

	// n pressed ticks, then the release tick
	function automatic int push_hold(int n, logic ok);
		repeat (n) push_item(KIND_TICK, 1'b0, 1'($urandom_range(1)));
		push_item(KIND_TICK, 1'b1, ok);
		return n + 1;
	endfunction

	function automatic int push_random_chunk();
		int sel;
		int n;
		int lim;
		sel = $urandom_range(99);
		if (sel < 55) begin
			lim = (long_ms > short_ms) ? int'(long_ms) : int'(short_ms);
			if (lim > 40)
				lim = 40;
			return push_hold($urandom_range(lim + 2, 1), 1'($urandom_range(1)));
		end
		if (sel < 70) begin
			lim = (auto_off > 50) ? 50 : int'(auto_off);
			n = $urandom_range(lim + 2, 1);
			repeat (n) push_item(KIND_TICK, 1'b1, 1'($urandom_range(1)));
			return n;
		end
		if (sel < 80)
			push_item(KIND_ACTIVITY, 1'($urandom_range(1)), 1'($urandom_range(1)));
		else if (sel < 90)
			push_item($urandom_range(1) ? KIND_START : KIND_STOP, 1'($urandom_range(1)),
				1'($urandom_range(1)));
		else
			push_item(kind_t'($urandom_range(3)), 1'($urandom_range(1)),
				1'($urandom_range(1)));
		return 1;
	endfunction

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_SHORT_HOLD: short_ms = val[HOLD_W-1:0];
			REG_LONG_HOLD:  long_ms = val[HOLD_W-1:0];
			REG_AUTO_OFF:   auto_off = val[IDLE_W-1:0];
			default: ;
		endcase
	endtask

	// junk in the upper bits of the 16-bit registers must be dropped
	task automatic load_thresholds(int unsigned s, int unsigned l, int unsigned a);
		logic [CFG_W-1:0] d;
		d = CFG_W'($urandom);
		d[HOLD_W-1:0] = HOLD_W'(s);
		write_reg(REG_SHORT_HOLD, d);
		d = CFG_W'($urandom);
		d[HOLD_W-1:0] = HOLD_W'(l);
		write_reg(REG_LONG_HOLD, d);
		write_reg(REG_AUTO_OFF, CFG_W'(a));
		@(negedge clk);
		cfg_we <= 1'b0;
		threshold_sets++;
	endtask

	task automatic drain();
		while (items_to_send.size() != 0 || predicted_status.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// sender
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (items_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				in_valid <= 1'b1;
				kind <= items_to_send[0].k;
				button_level <= items_to_send[0].lvl;
				start_ok <= items_to_send[0].ok;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver, with an occasional long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_off_left > 0) begin
			out_ready <= 1'b0;
			hold_off_left--;
		end else if (hold_off_asked != hold_off_served) begin
			hold_off_served = hold_off_asked;
			hold_off_left = HOLD_OFF_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : monitor
		result_t got;
		result_t want;
		in_taken = arst_n && in_valid && in_ready;
		if (in_taken) begin
			predicted_status.push_back(step_controller(kind_t'(kind), button_level, start_ok));
			items_to_send.delete(0);
		end
		if (arst_n && out_valid && out_ready) begin
			got = {service_active, tone_on, went_up, went_down, password_reset, beep_three,
				user_activity};
			if (predicted_status.size() == 0) begin
				$error("result transfer with no result pending");
				mismatches++;
			end else begin
				want = predicted_status.pop_front();
				results_checked++;
				for (int i = 0; i < $bits(result_t); i++) begin
					if (got[i] !== want[i]) begin
						$error("%s: expected %0b, got %0b", field_names[i], want[i], got[i]);
						mismatches++;
					end
				end
				starts_seen += want.went_up;
				stops_seen += want.went_down;
				resets_seen += want.password_reset;
				beeps_seen += want.beep_three;
			end
		end
	end

	initial begin : stimulus
		int pushed;
		int budget;
		short_ms = SHORT_HOLD_RST;
		long_ms = LONG_HOLD_RST;
		auto_off = AUTO_OFF_RST;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// press right after reset, then redundant and failing requests
		push_item(KIND_TICK, 1'b0, 1'b1);
		push_item(KIND_TICK, 1'b1, 1'b1);
		push_item(KIND_START, 1'b0, 1'b0);
		push_item(KIND_START, 1'b1, 1'b1);
		push_item(KIND_START, 1'b0, 1'b1);
		push_item(KIND_ACTIVITY, 1'b0, 1'b0);
		push_item(KIND_STOP, 1'b1, 1'b0);
		push_item(KIND_STOP, 1'b0, 1'b1);
		push_item(KIND_ACTIVITY, 1'b1, 1'b1);
		drain();
		load_thresholds(2, 4, 12);
		write_reg(UNUSED_REG, CFG_W'($urandom));
		@(negedge clk);
		cfg_we <= 1'b0;

		// toggle on with failed start, toggle on, short hold ignored, long-hold restart
		pushed = push_hold(2, 1'b0);
		pushed = push_hold(2, 1'b1);
		pushed = push_hold(1, 1'b1);
		pushed = push_hold(5, 1'b1);

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: load_thresholds($urandom_range(6, 1), $urandom_range(15, 1),
					$urandom_range(30, 1));
				1: load_thresholds(1, 1, 1);
				2: load_thresholds($urandom_range(10, 3), $urandom_range(5, 1),
					$urandom_range(60, 10));
				3: load_thresholds(32'hFFFF, 32'hFFFF, 32'(IDLE_MAX));
				default: load_thresholds($urandom_range(8, 1), $urandom_range(20, 1),
					$urandom_range(50, 1));
			endcase
			tx_idle_pct = (ph < 2) ? 12 : (ph < 4) ? 88 : 0;
			rx_idle_pct = (ph < 2) ? 88 : (ph < 4) ? 12 : 0;
			if (ph == 5)
				hold_off_asked++;
			budget = (ph == 3) ? 60 : 190;
			pushed = 0;
			while (pushed < budget)
				pushed += push_random_chunk();
		end
		drain();
		repeat (10) @(negedge clk);

		$display("checked %0d results over %0d threshold sets", results_checked,
			threshold_sets);
		$display("starts %0d, stops %0d, password resets %0d, triple beeps %0d",
			starts_seen, stops_seen, resets_seen, beeps_seen);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/lprt_pkg.sv
src/lprt_cfg.sv
src/lprt_step.sv
src/long_press_radio_toggle_controller_core.sv
verif/long_press_radio_toggle_controller_core_tb.sv
